[rtl/tic_pkg.sv]
// tic_pkg: shared types and codes for the Thumb instruction classifier.
// Query kinds, decode form codes and the pipeline stage records.
// No dependencies; every rtl file imports this package.
package tic_pkg;

    localparam int HalfWidth = 16;
    localparam int ImmWidth  = 32;
    localparam int RegWidth  = 4;
    localparam int OpWidth   = 5;

    // Query kind carried with each input word
    typedef enum logic [OpWidth-1:0] {
        OP_ADD_REG  = 5'd0,
        OP_MOV_IMM  = 5'd1,
        OP_MOVT     = 5'd2,
        OP_LDR_IMM  = 5'd3,
        OP_LDR_LIT  = 5'd4,
        OP_LDR_W    = 5'd5,
        OP_ADR      = 5'd6,
        OP_PUSH     = 5'd7,
        OP_POP      = 5'd8,
        OP_PUSH_W   = 5'd9,
        OP_POP_W    = 5'd10,
        OP_TST_W    = 5'd11,
        OP_BL       = 5'd12,
        OP_B32      = 5'd13,
        OP_B16      = 5'd14,
        OP_BNE_W    = 5'd15,
        OP_BEQ_W    = 5'd16,
        OP_ORR_W    = 5'd17,
        OP_STR_W    = 5'd18,
        OP_ADD_W    = 5'd19,
        OP_IS_32BIT = 5'd20
    } opcode_t;

    // Field layout of a matched encoding; FORM_NONE means no match
    typedef enum logic [4:0] {
        FORM_NONE,
        FORM_FLAG,        // matched, no fields
        FORM_ADD_LOW,     // rd = a[2:0], rs = a[8:6]
        FORM_ADD_HIGH,    // rd = {a[7], a[2:0]}, rs = a[6:3]
        FORM_ADD_REG_W,   // rd = b[11:8], rs = b[3:0]
        FORM_RD8_IMM8,    // rd = a[10:8], imm = a[7:0]
        FORM_MOV_W,       // rd = b[11:8], imm = expanded imm12
        FORM_IMM16,       // rd = b[11:8], imm = imm4:i:imm3:imm8
        FORM_LDR_IMM,     // rd = a[2:0], imm = a[10:6] * 4
        FORM_IMM12_B,     // imm = b[11:0]
        FORM_IMM8_B,      // imm = b[7:0]
        FORM_BL,          // imm = sign-extended BL offset
        FORM_BR32,        // imm = imm6:imm11
        FORM_BR16_U,      // imm = a[10:0]
        FORM_IMM8_A,      // imm = a[7:0]
        FORM_RRI,         // rd = b[11:8], rs = a[3:0], imm = b[7:0]
        FORM_STR_W        // rd = b[15:12], rs = a[3:0], imm = b[11:0]
    } form_t;

    // Stage 1 record: decoded form plus the raw halfwords
    typedef struct packed {
        form_t                 form;
        logic [HalfWidth-1:0]  first_halfword;
        logic [HalfWidth-1:0]  second_halfword;
    } dec_t;

    // Stage 2 record: fields extracted, immediate not yet expanded
    typedef struct packed {
        logic                 matched;
        logic                 expand;
        logic [RegWidth-1:0]  reg_dest;
        logic [RegWidth-1:0]  reg_src;
        logic [ImmWidth-1:0]  imm_value;
    } fld_t;

    // Stage 3 record: final result word
    typedef struct packed {
        logic [ImmWidth-1:0]  imm_value;
        logic [RegWidth-1:0]  reg_src;
        logic [RegWidth-1:0]  reg_dest;
        logic                 matched;
    } res_t;

endpackage

[rtl/tic_match.sv]
// tic_match: mask tests of one halfword pair against the queried kind.
// Produces a form code for the field extractor. Depends on tic_pkg.
module tic_match
    import tic_pkg::*;
(
    input  logic [HalfWidth-1:0] first_halfword,
    input  logic [HalfWidth-1:0] second_halfword,
    input  logic [OpWidth-1:0]   opcode,
    output form_t                form
);

    logic [HalfWidth-1:0] a;
    logic [HalfWidth-1:0] b;
    logic                 is_bl;
    logic                 b15;

    assign a   = first_halfword;
    assign b   = second_halfword;
    assign b15 = b[15];
    assign is_bl = (a[15:11] == 5'h1E) &&
                   (((b & 16'hD000) == 16'hD000) || ((b & 16'hD001) == 16'hC000));

    always_comb
    begin
        form = FORM_NONE;
        case (opcode)
            OP_ADD_REG:
            begin
                if ((a & 16'hFE00) == 16'h1800)
                    form = FORM_ADD_LOW;
                else if ((a & 16'hFF00) == 16'h4400)
                    form = FORM_ADD_HIGH;
                else if ((a & 16'hFFE0) == 16'hEB00)
                    form = FORM_ADD_REG_W;
            end
            OP_MOV_IMM:
            begin
                if ((a & 16'hF800) == 16'h2000)
                    form = FORM_RD8_IMM8;
                else if ((a & 16'hFBEF) == 16'hF04F && !b15)
                    form = FORM_MOV_W;
                else if ((a & 16'hFBF0) == 16'hF240 && !b15)
                    form = FORM_IMM16;
            end
            OP_MOVT:
                if ((a & 16'hFBF0) == 16'hF2C0 && !b15)
                    form = FORM_IMM16;
            OP_LDR_IMM:
                if (a[15:12] == 4'h6 && a[11])
                    form = FORM_LDR_IMM;
            OP_LDR_LIT:
                if (a[15:11] == 5'h09)
                    form = FORM_RD8_IMM8;
            OP_LDR_W:
                if ((a & 16'hF8D0) == 16'hF8D0)
                    form = FORM_IMM12_B;
            OP_ADR:
                if ((a & 16'hA000) == 16'hA000)
                    form = FORM_RD8_IMM8;
            OP_PUSH:
                if ((a & 16'hB400) == 16'hB400)
                    form = FORM_FLAG;
            OP_POP:
                if (a[15:9] == 7'h5E)
                    form = FORM_FLAG;
            OP_PUSH_W:
                if (a == 16'hE92D)
                    form = FORM_FLAG;
            OP_POP_W:
                if (a == 16'hE8BD)
                    form = FORM_FLAG;
            OP_TST_W:
                // bit 10 of the first halfword is a don't-care here
                if (!is_bl && ((a[15:5] & ~11'h020) == 11'h780))
                    form = FORM_IMM8_B;
            OP_BL:
                if (is_bl)
                    form = FORM_BL;
            OP_B32:
                if (a[15:11] == 5'h1E && b15)
                    form = FORM_BR32;
            OP_B16:
            begin
                if (a[15:11] == 5'h1C)
                    form = FORM_BR16_U;
                else if (a[15:12] == 4'hD)
                    form = FORM_IMM8_A;
            end
            OP_BNE_W:
                if ((a[15:6] & 10'h3C1) == 10'h3C1 && b15)
                    form = FORM_BR32;
            OP_BEQ_W:
                if ((a[15:6] & 10'h3C0) == 10'h3C0 && b15)
                    form = FORM_BR32;
            OP_ORR_W:
                if ((a[15:5] & 11'h782) == 11'h782 && !b15)
                    form = FORM_RRI;
            OP_STR_W:
                if (a[15:4] == 12'hF8C)
                    form = FORM_STR_W;
            OP_ADD_W:
                if (((a[15:5] & ~11'h020) == 11'h788) && !b15)
                    form = FORM_RRI;
            OP_IS_32BIT:
                if (a[15:13] == 3'b111 && a[12:11] != 2'b00)
                    form = FORM_FLAG;
            default:
                form = FORM_NONE;
        endcase
    end

endmodule

[rtl/tic_fields.sv]
// tic_fields: register and immediate extraction for a decoded form.
// The MOV.W immediate leaves here raw, flagged for expansion. Depends on tic_pkg.
module tic_fields
    import tic_pkg::*;
(
    input  dec_t dec,
    output fld_t fld
);

    logic [HalfWidth-1:0] a;
    logic [HalfWidth-1:0] b;
    logic                 s;
    logic                 i1;
    logic                 i2;

    assign a  = dec.first_halfword;
    assign b  = dec.second_halfword;
    assign s  = a[10];
    assign i1 = ~(b[13] ^ s);
    assign i2 = ~(b[11] ^ s);

    always_comb
    begin
        fld = '0;
        fld.matched = (dec.form != FORM_NONE);
        case (dec.form)
            FORM_ADD_LOW:
            begin
                fld.reg_dest = {1'b0, a[2:0]};
                fld.reg_src  = {1'b0, a[8:6]};
            end
            FORM_ADD_HIGH:
            begin
                fld.reg_dest = {a[7], a[2:0]};
                fld.reg_src  = a[6:3];
            end
            FORM_ADD_REG_W:
            begin
                fld.reg_dest = b[11:8];
                fld.reg_src  = b[3:0];
            end
            FORM_RD8_IMM8:
            begin
                fld.reg_dest  = {1'b0, a[10:8]};
                fld.imm_value = {24'd0, a[7:0]};
            end
            FORM_MOV_W:
            begin
                fld.reg_dest  = b[11:8];
                fld.expand    = 1'b1;
                fld.imm_value = {20'd0, a[10], b[14:12], b[7:0]};
            end
            FORM_IMM16:
            begin
                fld.reg_dest  = b[11:8];
                fld.imm_value = {16'd0, a[3:0], a[10], b[14:12], b[7:0]};
            end
            FORM_LDR_IMM:
            begin
                fld.reg_dest  = {1'b0, a[2:0]};
                fld.imm_value = {25'd0, a[10:6], 2'b00};
            end
            FORM_IMM12_B:
                fld.imm_value = {20'd0, b[11:0]};
            FORM_IMM8_B:
                fld.imm_value = {24'd0, b[7:0]};
            FORM_BL:
                fld.imm_value = {{8{s}}, i1, i2, a[9:0], b[10:0], 1'b0};
            FORM_BR32:
                fld.imm_value = {15'd0, a[5:0], b[10:0]};
            FORM_BR16_U:
                fld.imm_value = {21'd0, a[10:0]};
            FORM_IMM8_A:
                fld.imm_value = {24'd0, a[7:0]};
            FORM_RRI:
            begin
                fld.reg_dest  = b[11:8];
                fld.reg_src   = a[3:0];
                fld.imm_value = {24'd0, b[7:0]};
            end
            FORM_STR_W:
            begin
                fld.reg_dest  = b[15:12];
                fld.reg_src   = a[3:0];
                fld.imm_value = {20'd0, b[11:0]};
            end
            default:
                fld.imm_value = '0;
        endcase
    end

endmodule

[rtl/tic_expand.sv]
// tic_expand: modified-immediate expansion (replicate or rotate) of a
// 12-bit MOV.W constant; other immediates pass. Depends on tic_pkg.
module tic_expand
    import tic_pkg::*;
(
    input  fld_t fld,
    output res_t res
);

    logic [11:0]           imm12;
    logic [7:0]            byte_val;
    logic [ImmWidth-1:0]   rot_val;
    logic [4:0]            rot_amt;
    logic [2*ImmWidth-1:0] rot_pair;
    logic [ImmWidth-1:0]   expanded;

    assign imm12    = fld.imm_value[11:0];
    assign byte_val = imm12[7:0];
    assign rot_amt  = imm12[11:7];
    assign rot_val  = {24'd0, 1'b1, imm12[6:0]};
    assign rot_pair = {rot_val, rot_val} >> rot_amt;

    always_comb
    begin
        if (imm12[11:10] == 2'b00)
        begin
            case (imm12[9:8])
                2'd0:    expanded = {24'd0, byte_val};
                2'd1:    expanded = {8'd0, byte_val, 8'd0, byte_val};
                2'd2:    expanded = {byte_val, 8'd0, byte_val, 8'd0};
                default: expanded = {byte_val, byte_val, byte_val, byte_val};
            endcase
        end
        else
        begin
            // rotate right of 1:imm7 by imm12[11:7]
            expanded = rot_pair[ImmWidth-1:0];
        end
    end

    always_comb
    begin
        res.matched   = fld.matched;
        res.reg_dest  = fld.reg_dest;
        res.reg_src   = fld.reg_src;
        res.imm_value = fld.expand ? expanded : fld.imm_value;
    end

endmodule

[rtl/thumb_instruction_classifier.sv]
// thumb_instruction_classifier: top level, three-stage classify pipeline.
// Instantiates tic_match, tic_fields and tic_expand; depends on tic_pkg.
//
//  channel  | dir | tdata fields (lowest bit up)
//  ---------+-----+-------------------------------------------------------
//  s_*      | in  | first_halfword[15:0] second_halfword[31:16] opcode[36:32]
//  m_*      | out | matched[0] reg_dest[4:1] reg_src[8:5] imm_value[40:9]
//
// One word enters per cycle while s_tready is high; a result reaches m_* once
// its word has passed match, field extract and immediate expand, one register each.
// Reset clears the three stage valid bits; payload registers hold junk.
// Each stage advances when it is empty or the stage after it advances, so
// a stall on m_tready fills bubbles first and never drops or repeats.
module thumb_instruction_classifier
    import tic_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // first_halfword, second_halfword, opcode, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // matched, reg_dest, reg_src, imm_value, zero pad
);

    // Stage valid bits and payload
    logic v1_reg, v2_reg, v3_reg;
    logic v1_next, v2_next, v3_next;
    dec_t s1_reg, s1_next;
    fld_t s2_reg, s2_next;
    res_t s3_reg, s3_next;

    logic en1, en2, en3;

    form_t form;
    fld_t  fld;
    res_t  res;

    // Advance enables: a stage moves when empty or when its successor moves
    assign en3 = !v3_reg || m_tready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign s_tready = en1;

    // Stage 1: mask tests against the queried kind
    tic_match u_match (
        .first_halfword  (s_tdata[15:0]),
        .second_halfword (s_tdata[31:16]),
        .opcode          (s_tdata[36:32]),
        .form            (form)
    );

    // Stage 2: register and raw immediate extraction
    tic_fields u_fields (
        .dec (s1_reg),
        .fld (fld)
    );

    // Stage 3: modified-immediate expansion
    tic_expand u_expand (
        .fld (s2_reg),
        .res (res)
    );

    always_comb
    begin
        v1_next = en1 ? s_tvalid : v1_reg;
        v2_next = en2 ? v1_reg   : v2_reg;
        v3_next = en3 ? v2_reg   : v3_reg;

        // hold payload unless the stage advances with a live word
        s1_next = s1_reg;
        if (en1 && s_tvalid)
        begin
            s1_next.form            = form;
            s1_next.first_halfword  = s_tdata[15:0];
            s1_next.second_halfword = s_tdata[31:16];
        end

        s2_next = (en2 && v1_reg) ? fld : s2_reg;
        s3_next = (en3 && v2_reg) ? res : s3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        s2_reg <= s2_next;
        s3_reg <= s3_next;
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = {7'd0, s3_reg.imm_value, s3_reg.reg_src, s3_reg.reg_dest,
                       s3_reg.matched};

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: self-checking bench for thumb_instruction_classifier over its stream ports.
// Predicts each result word from the accepted query word and checks it in order.
// Depends on rtl/tic_pkg.sv and rtl/thumb_instruction_classifier.sv.
module tb_top;
    import tic_pkg::*;

    localparam int RandomQueries = 950;
    localparam int CycleLimit    = 300000;
    localparam int DrainCycles   = 8;     // three pipeline stages plus slack
    localparam int HoldOffCycles = 150;

    // One query word waiting to be driven; drain asks the driver to wait for an
    // empty pipeline before offering it
    typedef struct {
        logic [15:0] first_hw;
        logic [15:0] second_hw;
        logic [4:0]  kind;
        bit          drain;
    } query_t;

    // How the second halfword is shaped for a well-formed query
    typedef enum int {
        HW2_ANY,
        HW2_CLEAR15,
        HW2_SET15,
        HW2_BL
    } hw2_rule_t;

    // Receiver ready patterns, switched at random over the run
    typedef enum int {
        RX_ALWAYS,
        RX_MOSTLY,
        RX_RARELY,
        RX_TOGGLE
    } rx_mode_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // first_halfword[15:0] second_halfword[31:16] opcode[36:32]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;         // matched[0] reg_dest[4:1] reg_src[8:5] imm_value[40:9]

    query_t      pending_queries[$];
    res_t        expected_results[$];
    query_t      offer_query;
    res_t        got_result;
    res_t        want_result;
    bit          drained = 1'b1;
    int          mismatch_count = 0;
    int          gap_left;
    int          burst_left;
    int          rx_cycle;
    int          hold_left;
    rx_mode_t    rx_mode;
    int          cycle_count = 0;

    thumb_instruction_classifier dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // BL and BLX share the first halfword pattern; the second halfword test is
    // loose on purpose and must stay that way
    function automatic bit is_bl_pair(input logic [15:0] a, input logic [15:0] b);
        return (a[15:11] == 5'b11110) &&
               ((b[15] && b[14] && b[12]) || (b[15] && b[14] && !b[12] && !b[0]));
    endfunction

    // imm4:i:imm3:imm8 of MOVW / MOVT
    function automatic logic [31:0] wide_imm16(input logic [15:0] a, input logic [15:0] b);
        return {16'h0000, a[3:0], a[10], b[14:12], b[7:0]};
    endfunction

    // Expected result word for one query word
    function automatic res_t classify_query(input logic [15:0] a, input logic [15:0] b,
                                            input logic [4:0] kind);
        res_t        r;
        logic [31:0] br32;
        logic [11:0] imm12;
        logic [31:0] rot_src;
        logic [63:0] rot_pair;
        logic        sgn;
        r = '0;
        br32 = {15'h0000, a[5:0], b[10:0]};
        case (kind)
            OP_ADD_REG:
            begin
                if (a[15:9] == 7'b0001100)
                begin
                    r.matched = 1'b1; r.reg_dest = {1'b0, a[2:0]}; r.reg_src = {1'b0, a[8:6]};
                end
                else if (a[15:8] == 8'h44)
                begin
                    r.matched = 1'b1; r.reg_dest = {a[7], a[2:0]}; r.reg_src = a[6:3];
                end
                else if ((a & 16'hFFE0) == 16'hEB00)
                begin
                    r.matched = 1'b1; r.reg_dest = b[11:8]; r.reg_src = b[3:0];
                end
            end
            OP_MOV_IMM:
            begin
                if (a[15:11] == 5'b00100)
                begin
                    // the 16-bit form carries a full 8-bit immediate
                    r.matched = 1'b1; r.reg_dest = {1'b0, a[10:8]};
                    r.imm_value = {24'h0, a[7:0]};
                end
                else if ((a & 16'hFBEF) == 16'hF04F && !b[15])
                begin
                    r.matched = 1'b1; r.reg_dest = b[11:8];
                    imm12 = {a[10], b[14:12], b[7:0]};
                    if (imm12[11:10] == 2'b00)
                    begin
                        case (imm12[9:8])
                            2'd0: r.imm_value = {24'h0, imm12[7:0]};
                            2'd1: r.imm_value = {8'h0, imm12[7:0], 8'h0, imm12[7:0]};
                            2'd2: r.imm_value = {imm12[7:0], 8'h0, imm12[7:0], 8'h0};
                            default: r.imm_value = {4{imm12[7:0]}};
                        endcase
                    end
                    else
                    begin
                        // rotate 1:imm7 right by imm12[11:7], at least 8 here
                        rot_src = {24'h0, 1'b1, imm12[6:0]};
                        rot_pair = {rot_src, rot_src} >> imm12[11:7];
                        r.imm_value = rot_pair[31:0];
                    end
                end
                else if ((a & 16'hFBF0) == 16'hF240 && !b[15])
                begin
                    r.matched = 1'b1; r.reg_dest = b[11:8]; r.imm_value = wide_imm16(a, b);
                end
            end
            OP_MOVT:
            begin
                if ((a & 16'hFBF0) == 16'hF2C0 && !b[15])
                begin
                    r.matched = 1'b1; r.reg_dest = b[11:8]; r.imm_value = wide_imm16(a, b);
                end
            end
            OP_LDR_IMM:
            begin
                if (a[15:12] == 4'h6 && a[11])
                begin
                    r.matched = 1'b1; r.reg_dest = {1'b0, a[2:0]};
                    r.imm_value = {25'h0, a[10:6], 2'b00};
                end
            end
            OP_LDR_LIT:
            begin
                if (a[15:11] == 5'b01001)
                begin
                    r.matched = 1'b1; r.reg_dest = {1'b0, a[10:8]};
                    r.imm_value = {24'h0, a[7:0]};
                end
            end
            OP_LDR_W:
            begin
                if ((a & 16'hF8D0) == 16'hF8D0)
                begin
                    r.matched = 1'b1; r.imm_value = {20'h0, b[11:0]};
                end
            end
            OP_ADR:
            begin
                if ((a & 16'hA000) == 16'hA000)
                begin
                    r.matched = 1'b1; r.reg_dest = {1'b0, a[10:8]};
                    r.imm_value = {24'h0, a[7:0]};
                end
            end
            OP_PUSH:     r.matched = ((a & 16'hB400) == 16'hB400);
            OP_POP:      r.matched = (a[15:9] == 7'h5E);
            OP_PUSH_W:   r.matched = (a == 16'hE92D);
            OP_POP_W:    r.matched = (a == 16'hE8BD);
            OP_TST_W:
            begin
                if (!is_bl_pair(a, b) && ((a >> 5) & ~16'h0020) == 16'h0780)
                begin
                    r.matched = 1'b1; r.imm_value = {24'h0, b[7:0]};
                end
            end
            OP_BL:
            begin
                if (is_bl_pair(a, b))
                begin
                    // J1/J2 fold into I1/I2 against the sign bit
                    sgn = a[10];
                    r.matched = 1'b1;
                    r.imm_value = {{8{sgn}}, ~(b[13] ^ sgn), ~(b[11] ^ sgn),
                                   a[9:0], b[10:0], 1'b0};
                end
            end
            OP_B32:
            begin
                if (a[15:11] == 5'b11110 && b[15])
                begin
                    r.matched = 1'b1; r.imm_value = br32;
                end
            end
            OP_B16:
            begin
                if (a[15:11] == 5'b11100)
                begin
                    r.matched = 1'b1; r.imm_value = {21'h0, a[10:0]};
                end
                else if (a[15:12] == 4'hD)
                begin
                    r.matched = 1'b1; r.imm_value = {24'h0, a[7:0]};
                end
            end
            OP_BNE_W:
            begin
                if (((a >> 6) & 16'h03C1) == 16'h03C1 && b[15])
                begin
                    r.matched = 1'b1; r.imm_value = br32;
                end
            end
            OP_BEQ_W:
            begin
                if (((a >> 6) & 16'h03C0) == 16'h03C0 && b[15])
                begin
                    r.matched = 1'b1; r.imm_value = br32;
                end
            end
            OP_ORR_W:
            begin
                if (((a >> 5) & 16'h0782) == 16'h0782 && !b[15])
                begin
                    r.matched = 1'b1; r.reg_dest = b[11:8]; r.reg_src = a[3:0];
                    r.imm_value = {24'h0, b[7:0]};
                end
            end
            OP_STR_W:
            begin
                if (a[15:4] == 12'hF8C)
                begin
                    r.matched = 1'b1; r.reg_dest = b[15:12]; r.reg_src = a[3:0];
                    r.imm_value = {20'h0, b[11:0]};
                end
            end
            OP_ADD_W:
            begin
                if (((a >> 5) & ~16'h0020) == 16'h0788 && !b[15])
                begin
                    r.matched = 1'b1; r.reg_dest = b[11:8]; r.reg_src = a[3:0];
                    r.imm_value = {24'h0, b[7:0]};
                end
            end
            OP_IS_32BIT: r.matched = (a[15:13] == 3'b111) && (a[12:11] != 2'b00);
            default:     r = '0;   // unused kinds never match
        endcase
        return r;
    endfunction

    // Random query that mostly fits the pattern of its kind; the fixed bits of
    // the first halfword are forced, the rest stays random
    function automatic query_t shape_query(input logic [4:0] kind);
        query_t      q;
        logic [15:0] mask;
        logic [15:0] value;
        hw2_rule_t   rule;
        int          pick;
        q.first_hw = 16'($urandom);
        q.second_hw = 16'($urandom);
        q.kind = kind;
        q.drain = 1'b0;
        mask = 16'h0000;
        value = 16'h0000;
        rule = HW2_ANY;
        pick = $urandom_range(0, 2);
        case (kind)
            OP_ADD_REG:
            begin
                if (pick == 0)      begin mask = 16'hFE00; value = 16'h1800; end
                else if (pick == 1) begin mask = 16'hFF00; value = 16'h4400; end
                else                begin mask = 16'hFFE0; value = 16'hEB00; end
            end
            OP_MOV_IMM:
            begin
                if (pick == 0)      begin mask = 16'hF800; value = 16'h2000; end
                else if (pick == 1)
                begin
                    mask = 16'hFBEF; value = 16'hF04F; rule = HW2_CLEAR15;
                end
                else
                begin
                    mask = 16'hFBF0; value = 16'hF240; rule = HW2_CLEAR15;
                end
            end
            OP_MOVT:     begin mask = 16'hFBF0; value = 16'hF2C0; rule = HW2_CLEAR15; end
            OP_LDR_IMM:  begin mask = 16'hF800; value = 16'h6800; end
            OP_LDR_LIT:  begin mask = 16'hF800; value = 16'h4800; end
            OP_LDR_W:    begin mask = 16'hF8D0; value = 16'hF8D0; end
            OP_ADR:      begin mask = 16'hA000; value = 16'hA000; end
            OP_PUSH:     begin mask = 16'hB400; value = 16'hB400; end
            OP_POP:      begin mask = 16'hFE00; value = 16'hBC00; end
            OP_PUSH_W:   begin mask = 16'hFFFF; value = 16'hE92D; end
            OP_POP_W:    begin mask = 16'hFFFF; value = 16'hE8BD; end
            OP_TST_W:    begin mask = 16'hFBE0; value = 16'hF000; end
            OP_BL:       begin mask = 16'hF800; value = 16'hF000; rule = HW2_BL; end
            OP_B32:      begin mask = 16'hF800; value = 16'hF000; rule = HW2_SET15; end
            OP_B16:
            begin
                if (pick == 0) begin mask = 16'hF800; value = 16'hE000; end
                else           begin mask = 16'hF000; value = 16'hD000; end
            end
            OP_BNE_W:    begin mask = 16'hF040; value = 16'hF040; rule = HW2_SET15; end
            OP_BEQ_W:    begin mask = 16'hF000; value = 16'hF000; rule = HW2_SET15; end
            OP_ORR_W:    begin mask = 16'hF040; value = 16'hF040; rule = HW2_CLEAR15; end
            OP_STR_W:    begin mask = 16'hFFF0; value = 16'hF8C0; end
            OP_ADD_W:    begin mask = 16'hFBE0; value = 16'hF100; rule = HW2_CLEAR15; end
            OP_IS_32BIT: begin mask = 16'hE000; value = 16'hE000; end
            default:     mask = 16'h0000;
        endcase
        q.first_hw = (q.first_hw & ~mask) | value;
        // leave one in ten second halfwords unshaped to hit the near misses
        if ($urandom_range(0, 9) != 0)
        begin
            case (rule)
                HW2_CLEAR15: q.second_hw[15] = 1'b0;
                HW2_SET15:   q.second_hw[15] = 1'b1;
                HW2_BL:
                begin
                    q.second_hw[15:14] = 2'b11;
                    if ($urandom_range(0, 1) == 0)
                        q.second_hw[12] = 1'b1;
                    else
                    begin
                        q.second_hw[12] = 1'b0;
                        q.second_hw[0] = 1'b0;
                    end
                end
                default: q.second_hw[15] = q.second_hw[15];
            endcase
        end
        return q;
    endfunction

    task automatic add_query(input logic [15:0] a, input logic [15:0] b,
                             input logic [4:0] kind, input bit drain);
        query_t q;
        q.first_hw = a;
        q.second_hw = b;
        q.kind = kind;
        q.drain = drain;
        pending_queries.push_back(q);
    endtask

    // Driver: offer words from the pending queue in bursts with gaps between
    // them; hold the word while the block stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            gap_left <= 0;
            burst_left <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end
            else if (pending_queries.size() == 0)
                s_tvalid <= 1'b0;
            else if (pending_queries[0].drain && (s_tvalid || !drained))
                // pause until every outstanding word has come back
                s_tvalid <= 1'b0;
            else
            begin
                offer_query = pending_queries.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {3'b000, offer_query.kind, offer_query.second_hw,
                            offer_query.first_hw};
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // Receiver: switch ready patterns at random and twice hold ready low
    // for a long stretch so the pipeline fills and backs up into s_tready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_cycle <= 0;
            hold_left <= 0;
            rx_mode <= RX_ALWAYS;
        end
        else
        begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle % 50 == 0)
                rx_mode <= rx_mode_t'($urandom_range(0, 3));
            if (rx_cycle == 400 || rx_cycle == 1500)
            begin
                hold_left <= HoldOffCycles;
                m_tready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    RX_ALWAYS: m_tready <= 1'b1;
                    RX_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
                    RX_RARELY: m_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_tready <= rx_cycle[0];
                endcase
            end
        end
    end

    // Monitor: check the accepted result word against the oldest prediction,
    // then predict the query word accepted at this same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got_result = res_t'(m_tdata[40:0]);
                if (expected_results.size() == 0)
                begin
                    $error("result word with no query outstanding: %h", m_tdata);
                    mismatch_count = mismatch_count + 1;
                end
                else
                begin
                    want_result = expected_results.pop_front();
                    if (got_result.matched !== want_result.matched)
                    begin
                        $error("matched: expected %0d, got %0d",
                               want_result.matched, got_result.matched);
                        mismatch_count = mismatch_count + 1;
                    end
                    if (got_result.reg_dest !== want_result.reg_dest)
                    begin
                        $error("reg_dest: expected %0d, got %0d",
                               want_result.reg_dest, got_result.reg_dest);
                        mismatch_count = mismatch_count + 1;
                    end
                    if (got_result.reg_src !== want_result.reg_src)
                    begin
                        $error("reg_src: expected %0d, got %0d",
                               want_result.reg_src, got_result.reg_src);
                        mismatch_count = mismatch_count + 1;
                    end
                    if (got_result.imm_value !== want_result.imm_value)
                    begin
                        $error("imm_value: expected %h, got %h",
                               want_result.imm_value, got_result.imm_value);
                        mismatch_count = mismatch_count + 1;
                    end
                    if (m_tdata[47:41] !== 7'h00)
                    begin
                        $error("pad: expected %h, got %h", 7'h00, m_tdata[47:41]);
                        mismatch_count = mismatch_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(classify_query(s_tdata[15:0], s_tdata[31:16],
                                                          s_tdata[36:32]));
            drained <= (expected_results.size() == 0);
        end
    end

    // Watchdog: end a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial
    begin
        query_t shaped;

        // Directed words: at least one of every kind, field extremes, the loose
        // mask tests, the plain and rotated ThumbExpandImm forms and an unused kind
        add_query(16'h0000, 16'h0000, OP_IS_32BIT, 1'b0);
        add_query(16'h19C5, 16'h0000, OP_ADD_REG, 1'b0);   // add low registers
        add_query(16'h44FF, 16'h0000, OP_ADD_REG, 1'b0);   // add high registers
        add_query(16'hEB1F, 16'hFFFF, OP_ADD_REG, 1'b0);   // add.w register
        add_query(16'h27FF, 16'h0000, OP_MOV_IMM, 1'b0);   // 8-bit immediate all ones
        add_query(16'hF44F, 16'h7FFF, OP_MOV_IMM, 1'b0);   // rotated immediate
        add_query(16'hF04F, 16'h0312, OP_MOV_IMM, 1'b0);   // zero-extended byte
        add_query(16'hF24F, 16'h7FFF, OP_MOV_IMM, 1'b0);   // movw
        add_query(16'hF6CF, 16'h7FFF, OP_MOVT, 1'b0);
        add_query(16'h6FFF, 16'h0000, OP_LDR_IMM, 1'b0);
        add_query(16'h4FFF, 16'h0000, OP_LDR_LIT, 1'b0);
        add_query(16'hF8DF, 16'hFFFF, OP_LDR_W, 1'b0);
        add_query(16'hA7FF, 16'h0000, OP_ADR, 1'b0);
        add_query(16'hB5FF, 16'h0000, OP_PUSH, 1'b0);
        add_query(16'hBDFF, 16'h0000, OP_POP, 1'b0);
        add_query(16'hE92D, 16'h4FF0, OP_PUSH_W, 1'b0);
        add_query(16'hE8BD, 16'h8FF0, OP_POP_W, 1'b0);
        add_query(16'hF010, 16'h0FFF, OP_TST_W, 1'b0);
        add_query(16'hF7FF, 16'hFFFE, OP_BL, 1'b0);        // negative offset
        add_query(16'hF43F, 16'hAFFE, OP_B32, 1'b0);
        add_query(16'hD1FE, 16'h0000, OP_B16, 1'b0);
        add_query(16'hF47F, 16'hAFFE, OP_BNE_W, 1'b0);
        add_query(16'hF43F, 16'h8000, OP_BEQ_W, 1'b0);
        add_query(16'hF040, 16'h0101, OP_ORR_W, 1'b0);
        add_query(16'hF8CD, 16'h1FFF, OP_STR_W, 1'b0);
        add_query(16'hF10D, 16'h0D08, OP_ADD_W, 1'b0);
        add_query(16'hFFFF, 16'hFFFF, 5'd31, 1'b0);        // unused kind

        // Random words: three in four shaped to their kind, the rest noise over
        // all 32 kinds; drain the pipeline before a few of them
        for (int i = 0; i < RandomQueries; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                add_query(16'($urandom), 16'($urandom), 5'($urandom_range(0, 31)),
                          (i % 250) == 0);
            else
            begin
                shaped = shape_query(5'($urandom_range(0, 20)));
                shaped.drain = ((i % 250) == 0);
                pending_queries.push_back(shaped);
            end
        end

        repeat (4) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // Wait for the last word to go in and every result to come back
        while (pending_queries.size() != 0 || s_tvalid || !drained)
            @(negedge clk);
        repeat (DrainCycles) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

[filelist.f]
rtl/tic_pkg.sv
rtl/tic_match.sv
rtl/tic_fields.sv
rtl/tic_expand.sv
rtl/thumb_instruction_classifier.sv
sim/tb_top.sv
